>>> hdl/dsi_pkg.sv
// Shared types and constants for the decimal string to int64 parser.
package dsi_pkg;

    localparam int unsigned CHAR_W   = 8;
    localparam int unsigned VALUE_W  = 64;
    localparam int unsigned STATUS_W = 2;
    // magnitude * 10 + 9 stays below 2^67
    localparam int unsigned PROD_W   = VALUE_W + 4;

    localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

    localparam logic [VALUE_W-1:0] POS_LIMIT = {1'b0, {(VALUE_W-1){1'b1}}};
    localparam logic [VALUE_W-1:0] NEG_LIMIT = {1'b1, {(VALUE_W-1){1'b0}}};

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_INVALID  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        PH_LEAD   = 2'd0,
        PH_DIGITS = 2'd1,
        PH_DROP   = 2'd2
    } phase_t;

    // result of one parser step, decided from current state and character
    typedef struct packed {
        logic                has_result;
        logic [VALUE_W-1:0]  value;
        logic [STATUS_W-1:0] status;
    } step_res_t;

endpackage

>>> hdl/dsi_parser.sv
// Parser state and per-character next-state and result logic.
module dsi_parser (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        step,
    input  logic [dsi_pkg::CHAR_W-1:0]  character,
    output dsi_pkg::step_res_t          res
);

    dsi_pkg::phase_t               phase_reg, phase_next;
    logic                          neg_reg, neg_next;
    logic [dsi_pkg::VALUE_W-1:0]   mag_reg, mag_next;

    logic                          is_digit;
    logic                          is_space;
    logic [3:0]                    digit;
    logic [dsi_pkg::VALUE_W-1:0]   limit;
    logic [dsi_pkg::PROD_W-1:0]    mag_ext;
    logic [dsi_pkg::PROD_W-1:0]    prod;
    logic                          ovf;

    assign is_digit = (character >= dsi_pkg::CHAR_ZERO) && (character <= dsi_pkg::CHAR_NINE);
    assign is_space = (character == dsi_pkg::CHAR_SPACE) || (character == dsi_pkg::CHAR_TAB);
    assign digit    = 4'(character - dsi_pkg::CHAR_ZERO);
    assign limit    = neg_reg ? dsi_pkg::NEG_LIMIT : dsi_pkg::POS_LIMIT;
    assign mag_ext  = {4'b0000, mag_reg};
    // times ten as shift and add
    assign prod     = (mag_ext << 3) + (mag_ext << 1)
                    + {{(dsi_pkg::PROD_W-4){1'b0}}, digit};
    assign ovf      = prod > {4'b0000, limit};

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        neg_next   = neg_reg;
        mag_next   = mag_reg;
        unique case (phase_reg)
            dsi_pkg::PH_LEAD, dsi_pkg::PH_DIGITS:
            begin
                if (character == dsi_pkg::CHAR_NUL)
                begin
                    phase_next = dsi_pkg::PH_LEAD;
                    neg_next   = 1'b0;
                    mag_next   = '0;
                end
                else if (is_digit)
                begin
                    if (ovf)
                    begin
                        phase_next = dsi_pkg::PH_DROP;
                    end
                    else
                    begin
                        phase_next = dsi_pkg::PH_DIGITS;
                        mag_next   = prod[dsi_pkg::VALUE_W-1:0];
                    end
                end
                else if (phase_reg == dsi_pkg::PH_LEAD && is_space)
                begin
                    phase_next = dsi_pkg::PH_LEAD;
                end
                else if (phase_reg == dsi_pkg::PH_LEAD && character == dsi_pkg::CHAR_MINUS)
                begin
                    phase_next = dsi_pkg::PH_DIGITS;
                    neg_next   = 1'b1;
                end
                else if (phase_reg == dsi_pkg::PH_LEAD && character == dsi_pkg::CHAR_PLUS)
                begin
                    phase_next = dsi_pkg::PH_DIGITS;
                end
                else
                begin
                    phase_next = dsi_pkg::PH_DROP;
                end
            end
            default:
            begin
                // dropping (or unused code) until NUL
                if (character == dsi_pkg::CHAR_NUL)
                begin
                    phase_next = dsi_pkg::PH_LEAD;
                    neg_next   = 1'b0;
                    mag_next   = '0;
                end
            end
        endcase
    end

    // result
    always_comb
    begin
        res.has_result = 1'b0;
        res.value      = '0;
        res.status     = dsi_pkg::ST_OK;
        unique case (phase_reg)
            dsi_pkg::PH_LEAD, dsi_pkg::PH_DIGITS:
            begin
                if (character == dsi_pkg::CHAR_NUL)
                begin
                    res.has_result = 1'b1;
                    res.value      = neg_reg ? (~mag_reg + 64'd1) : mag_reg;
                    res.status     = dsi_pkg::ST_OK;
                end
                else if (is_digit)
                begin
                    if (ovf)
                    begin
                        res.has_result = 1'b1;
                        res.value      = limit;
                        res.status     = dsi_pkg::ST_OVERFLOW;
                    end
                end
                else if (phase_reg == dsi_pkg::PH_LEAD
                         && (is_space || character == dsi_pkg::CHAR_MINUS
                             || character == dsi_pkg::CHAR_PLUS))
                begin
                    res.has_result = 1'b0;
                end
                else
                begin
                    res.has_result = 1'b1;
                    res.value      = '0;
                    res.status     = dsi_pkg::ST_INVALID;
                end
            end
            default:
            begin
                res.has_result = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= dsi_pkg::PH_LEAD;
            neg_reg   <= 1'b0;
            mag_reg   <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            neg_reg   <= neg_next;
            mag_reg   <= mag_next;
        end
    end

    a_mag_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        mag_reg <= dsi_pkg::NEG_LIMIT)
        else $error("magnitude above 2^63");

    a_early_drops: assert property (@(posedge clk) disable iff (!rst_n)
        (step && res.has_result && res.status != dsi_pkg::ST_OK)
        |=> (phase_reg == dsi_pkg::PH_DROP))
        else $error("early result did not enter drop phase");

    a_nul_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (step && character == dsi_pkg::CHAR_NUL)
        |=> (phase_reg == dsi_pkg::PH_LEAD && !neg_reg && mag_reg == '0))
        else $error("NUL did not start a new string");

endmodule

>>> hdl/dsi_out_buf.sv
// Result register with valid/ready handshake toward the consumer.
module dsi_out_buf (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          load,
    input  logic [dsi_pkg::VALUE_W-1:0]   load_value,
    input  logic [dsi_pkg::STATUS_W-1:0]  load_status,
    output logic                          free,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [dsi_pkg::VALUE_W-1:0] value,
    output logic [dsi_pkg::STATUS_W-1:0]  status
);

    logic                          valid_reg;
    logic [dsi_pkg::VALUE_W-1:0]   value_reg;
    logic [dsi_pkg::STATUS_W-1:0]  status_reg;

    assign free      = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign value     = signed'(value_reg);
    assign status    = status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (free)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (free && load)
        begin
            value_reg  <= load_value;
            status_reg <= load_status;
        end
    end

endmodule

>>> hdl/decimal_string_to_int64_core.sv
// Top level: input register, parser step and result register.
// out_valid comes from the result register, which is loaded from the parser step.
// Throughput: one character per cycle; the parser step sits between the input
// register and the result register, and stalls only while the result register is full.
// Strings without an early result give one transaction at their NUL.
// Reset (rst_n low, asynchronous) empties both registers and restarts in the leading phase.
module decimal_string_to_int64_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [dsi_pkg::CHAR_W-1:0]    character,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [dsi_pkg::VALUE_W-1:0] value,
    output logic [dsi_pkg::STATUS_W-1:0]  status
);

    logic                          in_valid_reg;
    logic [dsi_pkg::CHAR_W-1:0]    char_reg;
    dsi_pkg::step_res_t            res;
    logic                          out_free;
    logic                          process;

    // a character with no result never waits on the output side
    assign process  = in_valid_reg && (!res.has_result || out_free);
    assign in_ready = !in_valid_reg || process;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            char_reg <= character;
        end
    end

    dsi_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (process),
        .character (char_reg),
        .res       (res)
    );

    dsi_out_buf u_out_buf (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (process && res.has_result),
        .load_value  (res.value),
        .load_status (res.status),
        .free        (out_free),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .value       (value),
        .status      (status)
    );

    a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (process && res.has_result) |=> out_valid)
        else $error("processed result missing at output");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (process && res.has_result) |-> (!out_valid || out_ready))
        else $error("result register overwritten");

endmodule
